[hdl/fixed_slot_pool_allocator_core_assert.svh]
// Assertion macros for the slot pool allocator.
// Include by bare file name where concurrent checks are written.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FSPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FSPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fspa_pkg.sv]
// Shared types and constants for the fixed slot pool allocator.
// Used by the link RAM wrapper users, the response stage and the top level.
package fspa_pkg;

   localparam int POOL_SLOTS  = 1024;
   localparam int LINK_ADDR_W = $clog2(POOL_SLOTS);
   localparam int HEAD_W      = LINK_ADDR_W + 1;
   localparam int SLOT_W      = 10;
   localparam int KIND_W      = 2;
   localparam int EB_W        = 13;
   localparam int EPB_W       = 11;
   localparam int OFFS_W      = 22;
   localparam int PROD_W      = SLOT_W + EB_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = EB_W;

   localparam logic [HEAD_W-1:0] SLOT_NULL = HEAD_W'(POOL_SLOTS);

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_BYTES      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENTS_PER_BLOCK = 1'b1;

   localparam logic [EB_W-1:0]  ELEMENT_BYTES_RESET      = 13'd8;
   localparam logic [EPB_W-1:0] ELEMENTS_PER_BLOCK_RESET = 11'd64;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] granted_slot;
      logic [OFFS_W-1:0] byte_offset;
   } rsp_type;

   // Decision made by the control logic, before byte scaling.
   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } res_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

endpackage

[hdl/fixed_slot_pool_allocator_core.sv]
// Fixed slot pool allocator, top level: free list control and block carving.
// Depends on fspa_pkg, fspa_link_ram, fspa_resp and the assertion header.
//
//   channel  ports                        direction  beat
//   req      req_valid/req_stall/req_data in         kind, slot
//   rsp      rsp_valid/rsp_stall/rsp_data out        ok, granted_slot, byte_offset
//   csr      csr_we/csr_index/csr_wdata   in         element_bytes, elements_per_block
//
// Free, clear, carve and failed requests are decided in ST_IDLE; an allocate that pops
// the free list stalls requests in ST_POP while the link memory reads the new head.
// Results leave through an output register with one skid entry.
// Reset is synchronous; the link memory is not cleared, entries become valid when freed.
// A stalled response fills the skid entry, after which req_stall rises.
`include "fixed_slot_pool_allocator_core_assert.svh"

module fixed_slot_pool_allocator_core import fspa_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type          state_ff, state_in;
   logic [EB_W-1:0]    element_bytes_ff;
   logic [EPB_W-1:0]   epb_ff;
   logic [HEAD_W-1:0]  free_head_ff, free_head_in;
   logic [EPB_W-1:0]   block_base_ff, block_base_in;
   logic [EPB_W-1:0]   block_offset_ff, block_offset_in;
   logic               any_open_ff, any_open_in;

   logic               accept;
   logic               res_ready;
   res_type            res;
   logic               head_valid;
   logic               slot_in_pool;
   logic               need_new;
   logic [EPB_W:0]     next_base;
   logic [EPB_W+1:0]   next_top;
   logic               carve_fail;
   logic [EPB_W-1:0]   carve_base;
   logic [EPB_W-1:0]   carve_left;
   logic [EPB_W-1:0]   carve_offset;
   logic [EPB_W-1:0]   carve_slot;

   logic               link_we;
   logic               link_re;
   logic [HEAD_W-1:0]  link_rd_data;

   assign req_stall = !((state_ff == ST_IDLE) && res_ready);
   assign accept    = req_valid && !req_stall;

   assign head_valid   = free_head_ff < SLOT_NULL;
   assign slot_in_pool = HEAD_W'(req_data.slot) < SLOT_NULL;

   // carving: open the next block directly above the current one when used up, or at 0 when none is open
   assign need_new   = !any_open_ff || (block_offset_ff == '0);
   assign next_base  = any_open_ff ? ((EPB_W+1)'(block_base_ff) + (EPB_W+1)'(epb_ff)) : '0;
   assign next_top   = (EPB_W+2)'(next_base) + (EPB_W+2)'(epb_ff);
   assign carve_fail = need_new && ((epb_ff == '0) || (next_top > (EPB_W+2)'(POOL_SLOTS)));
   assign carve_base = need_new ? next_base[EPB_W-1:0] : block_base_ff;
   assign carve_left = need_new ? epb_ff : block_offset_ff;
   assign carve_offset = carve_left - EPB_W'(1);
   assign carve_slot   = carve_base + carve_offset;

   assign link_we = accept && (req_data.kind == KIND_FREE) && slot_in_pool;
   assign link_re = accept && (req_data.kind == KIND_ALLOC) && head_valid;

   always_comb begin
      state_in        = state_ff;
      free_head_in    = free_head_ff;
      block_base_in   = block_base_ff;
      block_offset_in = block_offset_ff;
      any_open_in     = any_open_ff;
      res.ok          = 1'b0;
      res.slot        = '0;
      unique case (state_ff)
         ST_POP: begin
            // take the new head from the link memory
            free_head_in = link_rd_data;
            state_in     = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_ALLOC: begin
                     if (head_valid) begin
                        res.ok   = 1'b1;
                        res.slot = free_head_ff[SLOT_W-1:0];
                        state_in = ST_POP;
                     end else if (!carve_fail) begin
                        res.ok          = 1'b1;
                        res.slot        = carve_slot[SLOT_W-1:0];
                        block_base_in   = carve_base;
                        block_offset_in = carve_offset;
                        any_open_in     = 1'b1;
                     end
                  end
                  KIND_FREE: begin
                     if (slot_in_pool) begin
                        res.ok       = 1'b1;
                        res.slot     = req_data.slot;
                        free_head_in = HEAD_W'(req_data.slot);
                     end
                  end
                  KIND_CLEAR: begin
                     res.ok          = 1'b1;
                     free_head_in    = SLOT_NULL;
                     block_base_in   = '0;
                     block_offset_in = '0;
                     any_open_in     = 1'b0;
                  end
                  KIND_UNUSED: begin
                     res.ok = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         free_head_ff     <= SLOT_NULL;
         block_base_ff    <= '0;
         block_offset_ff  <= '0;
         any_open_ff      <= 1'b0;
         element_bytes_ff <= ELEMENT_BYTES_RESET;
         epb_ff           <= ELEMENTS_PER_BLOCK_RESET;
      end else begin
         state_ff        <= state_in;
         free_head_ff    <= free_head_in;
         block_base_ff   <= block_base_in;
         block_offset_ff <= block_offset_in;
         any_open_ff     <= any_open_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ELEMENT_BYTES:      element_bytes_ff <= csr_wdata;
               CSR_ELEMENTS_PER_BLOCK: epb_ff           <= csr_wdata[EPB_W-1:0];
            endcase
         end
      end
   end

   fspa_link_ram #(
      .DEPTH (POOL_SLOTS),
      .WIDTH (HEAD_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (req_data.slot[LINK_ADDR_W-1:0]),
      .wr_data (free_head_ff),
      .rd_en   (link_re),
      .rd_addr (free_head_ff[LINK_ADDR_W-1:0]),
      .rd_data (link_rd_data)
   );

   fspa_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .res_valid     (accept),
      .res_ready     (res_ready),
      .res           (res),
      .element_bytes (element_bytes_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   `FSPA_ASSERT_NEXT(a_pop_follows, link_re, state_ff == ST_POP, "pop did not wait for link read")
   `FSPA_ASSERT_NEXT(a_pop_one_cycle, state_ff == ST_POP, state_ff == ST_IDLE, "pop state held")
   `FSPA_ASSERT_NOW(a_pop_stalls, state_ff == ST_POP, req_stall, "request taken during pop")
   `FSPA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_data.ok, rsp_data.byte_offset == '0, "failed beat has offset")

endmodule

[hdl/fspa_link_ram.sv]
// Next-link memory of the free list: one write port, one read port.
// Read data is registered and appears in the cycle after the read enable. No dependencies.
module fspa_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/fspa_resp.sv]
// Response stage: scales the slot to a byte offset and holds result beats.
// Output register plus one skid entry. Depends on fspa_pkg.
module fspa_resp import fspa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   output logic            res_ready,
   input  res_type         res,
   input  logic [EB_W-1:0] element_bytes,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           out_ff, out_in;
   rsp_type           skid_ff, skid_in;
   rsp_type           beat;
   logic [PROD_W-1:0] prod;
   logic              take;
   logic              push;

   assign prod = PROD_W'(res.slot) * PROD_W'(element_bytes);

   always_comb begin
      beat.ok           = res.ok;
      beat.granted_slot = res.slot;
      beat.byte_offset  = res.ok ? prod[OFFS_W-1:0] : '0;
   end

   assign res_ready = !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign push      = res_valid && res_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         // drain the skid entry first, it is older
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in       = beat;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
